FILE: rtl/rstab_pkg.sv
// ----------------------------------------------------------------------------
// rstab_pkg
// Shared types and constants for the recent station table.
// ----------------------------------------------------------------------------
package rstab_pkg;

    // table geometry
    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

    // field widths
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned ID_W    = 48;
    localparam int unsigned SIG_W   = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ENTRY_W = ID_W + SIG_W + TIME_W;

    // ttl after reset, in ms
    localparam logic [TIME_W-1:0] TTL_RESET_MS = 32'd15000;

    // function codes
    localparam logic FUNC_DETECT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_QREAD,
        ST_QEVAL
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic             latch_in;
        logic             rd_en;
        logic             rd_query;
        logic [IDX_W-1:0] rd_idx;
        logic             write_det;
        logic             eval_query;
    } cmd_t;

endpackage

FILE: rtl/recent_station_table_core.sv
// Detect: SCAN reads every entry, LAST compares the last, WRITE loads the output;
// Query: QREAD reads one entry, QEVAL loads the output; both then take the next input.
// Detect time is set by the scan of all entries through the single RAM read port.
// A finished result waits in the output register while the next item is taken.
// Reset clears all valid bits at once and sets ttl_ms to 15000; no clearing pass.
// ----------------------------------------------------------------------------
// recent_station_table_core
// Table of recently heard stations with least-recently-seen replacement.
// ----------------------------------------------------------------------------
module recent_station_table_core
    import rstab_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [ID_W-1:0]          station_id,
    input  logic signed [SIG_W-1:0]  signal_dbm,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic [SLOT_W-1:0]        slot_index,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SLOT_W-1:0]        slot,
    output logic                     hit,
    output logic                     entry_live,
    output logic [ID_W-1:0]          entry_id,
    output logic signed [SIG_W-1:0]  entry_signal,
    output logic [TIME_W-1:0]        entry_age_ms,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [TIME_W-1:0]        cfg_data
);

    cmd_t cmd;

    // ttl register takes a write at any time
    assign cfg_ready = 1'b1;

    rstab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rstab_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .station_id   (station_id),
        .signal_dbm   (signal_dbm),
        .now_ms       (now_ms),
        .slot_index   (slot_index),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .slot         (slot),
        .hit          (hit),
        .entry_live   (entry_live),
        .entry_id     (entry_id),
        .entry_signal (entry_signal),
        .entry_age_ms (entry_age_ms)
    );

endmodule

FILE: rtl/rstab_ram.sv
// ----------------------------------------------------------------------------
// rstab_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rstab_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rstab_ctrl.sv
// ----------------------------------------------------------------------------
// rstab_ctrl
// Sequencer for the station table: scans the entries for a detect, reads one
// entry for a query, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rstab_ctrl
    import rstab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic func,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    // output register can take a new beat
    assign out_free = !out_valid_reg || !out_stall;

    // state, counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    cnt_next     = '0;
                    state_next   = (func == FUNC_QUERY) ? ST_QREAD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = cnt_reg;
                if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                // last entry is compared in this cycle
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.write_det  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_QREAD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_query = 1'b1;
                state_next   = ST_QEVAL;
            end
            ST_QEVAL:
            begin
                if (out_free)
                begin
                    cmd.eval_query = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/rstab_datapath.sv
// ----------------------------------------------------------------------------
// rstab_datapath
// Entry storage, valid bits, scan trackers for match, free slot and oldest
// entry, query age check and the output register.
// ----------------------------------------------------------------------------
module rstab_datapath
    import rstab_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [ID_W-1:0]          station_id,
    input  logic signed [SIG_W-1:0]  signal_dbm,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic [SLOT_W-1:0]        slot_index,
    input  logic                     cfg_valid,
    input  logic [TIME_W-1:0]        cfg_data,
    output logic [SLOT_W-1:0]        slot,
    output logic                     hit,
    output logic                     entry_live,
    output logic [ID_W-1:0]          entry_id,
    output logic signed [SIG_W-1:0]  entry_signal,
    output logic [TIME_W-1:0]        entry_age_ms
);

    // latched item
    logic [ID_W-1:0]         id_reg;
    logic signed [SIG_W-1:0] sig_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [SLOT_W-1:0]       qidx_reg;

    // configuration
    logic [TIME_W-1:0]       ttl_reg;

    // table valid bits
    logic [TABLE_DEPTH-1:0]  valid_reg;

    // scan trackers
    logic                    eval_en_reg;
    logic [IDX_W-1:0]        eval_idx_reg;
    logic                    match_found_reg;
    logic [IDX_W-1:0]        match_idx_reg;
    logic                    inv_found_reg;
    logic [IDX_W-1:0]        inv_idx_reg;
    logic [TIME_W-1:0]       min_seen_reg;
    logic [IDX_W-1:0]        victim_reg;

    // output register
    logic [SLOT_W-1:0]       slot_reg;
    logic                    hit_reg;
    logic                    live_reg;
    logic [ID_W-1:0]         eid_reg;
    logic signed [SIG_W-1:0] esig_reg;
    logic [TIME_W-1:0]       age_reg;

    // memory interface
    logic [IDX_W-1:0]        q_addr;
    logic [IDX_W-1:0]        raddr;
    logic [IDX_W-1:0]        chosen;
    logic [ENTRY_W-1:0]      rd_data;
    logic [ID_W-1:0]         rd_id;
    logic signed [SIG_W-1:0] rd_sig;
    logic [TIME_W-1:0]       rd_seen;
    logic                    eval_valid;
    logic                    q_valid;
    logic [TIME_W-1:0]       q_age;

    assign q_addr  = IDX_W'(qidx_reg);
    assign raddr   = cmd.rd_query ? q_addr : cmd.rd_idx;
    assign rd_id   = rd_data[ENTRY_W-1 -: ID_W];
    assign rd_sig  = rd_data[TIME_W +: SIG_W];
    assign rd_seen = rd_data[TIME_W-1:0];

    // matched slot first, then lowest free slot, then oldest entry
    assign chosen = match_found_reg ? match_idx_reg :
                    inv_found_reg   ? inv_idx_reg   : victim_reg;

    // query slot status and age
    assign eval_valid = valid_reg[eval_idx_reg];
    assign q_valid    = (32'(qidx_reg) < 32'(TABLE_DEPTH)) && valid_reg[q_addr];
    assign q_age      = now_reg - rd_seen;

    rstab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (cmd.write_det),
        .waddr (chosen),
        .wdata ({id_reg, sig_reg, now_reg}),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            id_reg   <= station_id;
            sig_reg  <= signal_dbm;
            now_reg  <= now_ms;
            qidx_reg <= slot_index;
        end
    end

    // ttl register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TTL_RESET_MS;
        end
        else if (cfg_valid)
        begin
            ttl_reg <= cfg_data;
        end
    end

    // valid bits and scan compare enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            eval_en_reg <= 1'b0;
        end
        else
        begin
            eval_en_reg <= cmd.rd_en && !cmd.rd_query;
            if (cmd.write_det)
            begin
                valid_reg[chosen] <= 1'b1;
            end
        end
    end

    // scan trackers, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            eval_idx_reg <= raddr;
        end
        if (cmd.latch_in)
        begin
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            inv_found_reg   <= 1'b0;
            inv_idx_reg     <= '0;
            min_seen_reg    <= '1;
            victim_reg      <= '0;
        end
        else if (eval_en_reg)
        begin
            if (eval_valid && (rd_id == id_reg) && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= eval_idx_reg;
            end
            if (!eval_valid && !inv_found_reg)
            begin
                inv_found_reg <= 1'b1;
                inv_idx_reg   <= eval_idx_reg;
            end
            if (eval_valid && (rd_seen < min_seen_reg))
            begin
                min_seen_reg <= rd_seen;
                victim_reg   <= eval_idx_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.write_det)
        begin
            slot_reg <= SLOT_W'(chosen);
            hit_reg  <= match_found_reg;
            live_reg <= 1'b1;
            eid_reg  <= id_reg;
            esig_reg <= sig_reg;
            age_reg  <= '0;
        end
        else if (cmd.eval_query)
        begin
            slot_reg <= qidx_reg;
            hit_reg  <= 1'b0;
            live_reg <= q_valid && (q_age <= ttl_reg);
            eid_reg  <= q_valid ? rd_id   : '0;
            esig_reg <= q_valid ? rd_sig  : '0;
            age_reg  <= q_valid ? q_age   : '0;
        end
    end

    assign slot         = slot_reg;
    assign hit          = hit_reg;
    assign entry_live   = live_reg;
    assign entry_id     = eid_reg;
    assign entry_signal = esig_reg;
    assign entry_age_ms = age_reg;

endmodule

FILE: rtl/rstab_checker.sv
// ----------------------------------------------------------------------------
// rstab_checker
// Port-level checks on the station table core, bound to the top level.
// ----------------------------------------------------------------------------
module rstab_checker
    import rstab_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    func,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SLOT_W-1:0]       slot,
    input logic                    hit,
    input logic                    entry_live,
    input logic [ID_W-1:0]         entry_id,
    input logic signed [SIG_W-1:0] entry_signal,
    input logic [TIME_W-1:0]       entry_age_ms
);

    // one item at a time: input held off right after a beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot) && $stable(hit)
            && $stable(entry_live) && $stable(entry_id)
            && $stable(entry_signal) && $stable(entry_age_ms))
        else $error("stalled result beat changed");

    // a matched detect was just written, so it is live with age zero
    a_hit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> entry_live && (entry_age_ms == '0))
        else $error("hit result not live or nonzero age");

    // a query into an empty output register loads its result after QREAD and QEVAL
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_QUERY) && !out_valid |=> ##2 out_valid)
        else $error("query result late");

endmodule

bind recent_station_table_core rstab_checker u_rstab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot         (slot),
    .hit          (hit),
    .entry_live   (entry_live),
    .entry_id     (entry_id),
    .entry_signal (entry_signal),
    .entry_age_ms (entry_age_ms)
);

FILE: bench/recent_station_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recent_station_table_core_tb
// Drives detect and query beats into the station table under random input
// gaps and output stalls. Each result is checked against a directed report
// or an internal model of the table and ttl register, at the block's widths.
// ----------------------------------------------------------------------------
module recent_station_table_core_tb;
    import rstab_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_BEATS = 160;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned IDLE_PCT    = 38;

    typedef struct packed {
        logic                    func;
        logic [ID_W-1:0]         station_id;
        logic signed [SIG_W-1:0] signal_dbm;
        logic [TIME_W-1:0]       now_ms;
        logic [SLOT_W-1:0]       slot_index;
    } station_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic                    hit;
        logic                    live;
        logic [ID_W-1:0]         id;
        logic signed [SIG_W-1:0] level;
        logic [TIME_W-1:0]       age;
    } station_report_t;

    typedef struct {
        station_beat_t   beat;
        bit              known;
        station_report_t want;
    } directed_row_t;

    // dut ports
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic                    func         = FUNC_DETECT;
    logic [ID_W-1:0]         station_id   = '0;
    logic signed [SIG_W-1:0] signal_dbm   = '0;
    logic [TIME_W-1:0]       now_ms       = '0;
    logic [SLOT_W-1:0]       slot_index   = '0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic [SLOT_W-1:0]       slot;
    logic                    hit;
    logic                    entry_live;
    logic [ID_W-1:0]         entry_id;
    logic signed [SIG_W-1:0] entry_signal;
    logic [TIME_W-1:0]       entry_age_ms;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [TIME_W-1:0]       cfg_data     = '0;

    // model of the table contents and the ttl register
    logic                    known_valid [TABLE_DEPTH];
    logic [ID_W-1:0]         known_id    [TABLE_DEPTH];
    logic signed [SIG_W-1:0] known_level [TABLE_DEPTH];
    logic [TIME_W-1:0]       known_seen  [TABLE_DEPTH];
    logic [TIME_W-1:0]       live_limit_ms;

    station_report_t pending_reports [$];
    directed_row_t   directed_rows [$];
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    bit              calm = 1'b0;
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;

    recent_station_table_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .station_id   (station_id),
        .signal_dbm   (signal_dbm),
        .now_ms       (now_ms),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .hit          (hit),
        .entry_live   (entry_live),
        .entry_id     (entry_id),
        .entry_signal (entry_signal),
        .entry_age_ms (entry_age_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("recent_station_table_core: mismatch");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // apply one beat to the table model and return the report it yields
    function automatic station_report_t track_station(input station_beat_t b);
        station_report_t   r;
        bit                found;
        bit                free;
        int unsigned       pick;
        int unsigned       victim;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] age;
        r = '0;
        if (b.func == FUNC_DETECT)
        begin
            found  = 1'b0;
            free   = 1'b0;
            pick   = 0;
            victim = 0;
            oldest = '1;
            // a live id match wins
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (!found && known_valid[i] && known_id[i] == b.station_id)
                begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            // else first free slot, else least recently seen, lowest index on tie
            if (!found)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!free && !known_valid[i])
                    begin
                        free = 1'b1;
                        pick = i;
                    end
                    else if (known_valid[i] && known_seen[i] < oldest)
                    begin
                        oldest = known_seen[i];
                        victim = i;
                    end
                end
                if (!free)
                    pick = victim;
            end
            known_valid[pick] = 1'b1;
            known_id[pick]    = b.station_id;
            known_level[pick] = b.signal_dbm;
            known_seen[pick]  = b.now_ms;
            r.slot  = SLOT_W'(pick);
            r.hit   = found;
            r.live  = 1'b1;
            r.id    = b.station_id;
            r.level = b.signal_dbm;
            r.age   = '0;
        end
        else
        begin
            r.slot = b.slot_index;
            if (b.slot_index < TABLE_DEPTH && known_valid[b.slot_index])
            begin
                age     = b.now_ms - known_seen[b.slot_index];
                r.live  = (age <= live_limit_ms);
                r.id    = known_id[b.slot_index];
                r.level = known_level[b.slot_index];
                r.age   = age;
            end
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] random_station();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[ID_W-1:0];
    endfunction

    // one directed row; the expected report is used only when known is set
    task automatic plan(input bit known, input logic f, input logic [ID_W-1:0] id,
                        input logic signed [SIG_W-1:0] sg, input logic [TIME_W-1:0] t,
                        input logic [SLOT_W-1:0] ix, input logic [SLOT_W-1:0] w_slot,
                        input logic w_hit, input logic w_live, input logic [ID_W-1:0] w_id,
                        input logic signed [SIG_W-1:0] w_level,
                        input logic [TIME_W-1:0] w_age);
        directed_row_t row;
        row.beat  = '{f, id, sg, t, ix};
        row.known = known;
        row.want  = '{w_slot, w_hit, w_live, w_id, w_level, w_age};
        directed_rows.push_back(row);
    endtask

    // send one input beat, entered and left at a falling edge
    task automatic send_beat(input station_beat_t b, input bit known,
                             input station_report_t want);
        station_report_t got;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= b.func;
        station_id <= b.station_id;
        signal_dbm <= b.signal_dbm;
        now_ms     <= b.now_ms;
        slot_index <= b.slot_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = track_station(b);
        pending_reports.push_back(known ? want : got);
        @(negedge clk);
    endtask

    // ttl write, only with the block idle
    task automatic write_ttl(input logic [TIME_W-1:0] value);
        in_valid  <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        live_limit_ms = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result beat checker
    always @(posedge clk)
    begin : report_check
        station_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no report pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("slot", 64'(want.slot), 64'(slot));
                check_field("hit", 64'(want.hit), 64'(hit));
                check_field("entry_live", 64'(want.live), 64'(entry_live));
                check_field("entry_id", 64'(want.id), 64'(entry_id));
                check_field("entry_signal", 64'(unsigned'(want.level)),
                            64'(unsigned'(entry_signal)));
                check_field("entry_age_ms", 64'(want.age), 64'(entry_age_ms));
            end
        end
    end

    // stimulus
    initial
    begin
        station_beat_t   b;
        station_report_t none;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] ttl_plan [5];
        int unsigned       roll;

        none = '0;
        live_limit_ms = TTL_RESET_MS;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            known_valid[i] = 1'b0;
            known_id[i]    = '0;
            known_level[i] = '0;
            known_seen[i]  = '0;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = random_station();

        // directed table, ttl at its reset value
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'd0, 4'd0,
             4'd0, 1'b0, 1'b0, 48'h0, 8'sd0, 32'd0);
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'hFFFF_FFFF, 4'd15,
             4'd15, 1'b0, 1'b0, 48'h0, 8'sd0, 32'd0);
        plan(1'b1, FUNC_DETECT, 48'h0, -8'sd128, 32'd0, 4'd0,
             4'd0, 1'b0, 1'b1, 48'h0, -8'sd128, 32'd0);
        plan(1'b1, FUNC_DETECT, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'hFFFF_FFFF, 4'd15,
             4'd1, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'd0);
        plan(1'b1, FUNC_DETECT, 48'h0, 8'sd5, 32'd100, 4'd0,
             4'd0, 1'b1, 1'b1, 48'h0, 8'sd5, 32'd0);
        // age right at the ttl is still live, one past is not
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'd15100, 4'd0,
             4'd0, 1'b0, 1'b1, 48'h0, 8'sd5, 32'd15000);
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'd15101, 4'd0,
             4'd0, 1'b0, 1'b0, 48'h0, 8'sd5, 32'd15001);
        // age wraps modulo 2^32
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'd0, 4'd1,
             4'd1, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'd1);
        plan(1'b1, FUNC_QUERY,  48'h0, 8'sd0, 32'd50, 4'd0,
             4'd0, 1'b0, 1'b0, 48'h0, 8'sd5, 32'hFFFF_FFCE);
        // fill the remaining slots, then force a replacement
        for (int k = 2; k < TABLE_DEPTH; k++)
            plan(1'b0, FUNC_DETECT, 48'hA5A5_0000_0000 + 48'(k), SIG_W'(k * 9),
                 32'd200 + 32'(k), 4'd0, 4'd0, 1'b0, 1'b0, 48'h0, 8'sd0, 32'd0);
        plan(1'b0, FUNC_DETECT, 48'h1234_5678_9ABC, -8'sd1, 32'd500, 4'd0,
             4'd0, 1'b0, 1'b0, 48'h0, 8'sd0, 32'd0);
        plan(1'b0, FUNC_QUERY,  48'h0, 8'sd0, 32'd600, 4'd0,
             4'd0, 1'b0, 1'b0, 48'h0, 8'sd0, 32'd0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            send_beat(directed_rows[k].beat, directed_rows[k].known, directed_rows[k].want);

        // random phases, one ttl setting each
        ttl_plan[0] = '0;
        ttl_plan[1] = '1;
        ttl_plan[2] = TIME_W'($urandom_range(1, 3000));
        ttl_plan[3] = TTL_RESET_MS;
        ttl_plan[4] = $urandom;
        clock_ms = 32'd1000;
        for (int p = 0; p < 5; p++)
        begin
            write_ttl(ttl_plan[p]);
            calm = (p == 2);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // advance the time base
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    clock_ms = clock_ms;
                else if (roll < 70)
                    clock_ms = clock_ms + TIME_W'($urandom_range(1, 50));
                else if (roll < 90)
                    clock_ms = clock_ms + TIME_W'($urandom_range(51, 5000));
                else
                    clock_ms = $urandom;

                b.func       = ($urandom_range(0, 1) == 0) ? FUNC_DETECT : FUNC_QUERY;
                b.station_id = ($urandom_range(0, 99) < 70)
                             ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                             : random_station();
                b.signal_dbm = SIG_W'($urandom);
                b.slot_index = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
                roll = $urandom_range(0, 99);
                if (roll < 85)
                    b.now_ms = clock_ms;
                else if (roll < 90)
                    b.now_ms = '1;
                else if (roll < 95)
                    b.now_ms = '0;
                else
                    b.now_ms = $urandom;
                // every slot seen at the latest time, ties fall to slot 0
                if (p == 3 && b.func == FUNC_DETECT)
                begin
                    b.now_ms = '1;
                    if ($urandom_range(0, 99) < 70)
                        b.station_id = random_station();
                end
                send_beat(b, 1'b0, none);
            end
        end
        calm = 1'b0;

        // drain
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("recent_station_table_core: match");
        else
            $display("recent_station_table_core: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rstab_pkg.sv
rtl/rstab_ram.sv
rtl/rstab_ctrl.sv
rtl/rstab_datapath.sv
rtl/recent_station_table_core.sv
rtl/rstab_checker.sv
bench/recent_station_table_core_tb.sv
